FILE: sv/oaids_pkg.sv
package oaids_pkg;

    // default number of element cells
    localparam int CAPACITY_DEF = 16;

    // fixed field widths
    localparam int OP_W    = 2;
    localparam int DATA_W  = 32;
    localparam int POS_W   = 5;
    localparam int STAT_W  = 3;
    localparam int FIELD_W = 5;

    typedef enum logic [OP_W-1:0] {
        OP_INSERT   = 2'd0,
        OP_DELETE   = 2'd1,
        OP_SEARCH   = 2'd2,
        OP_TRAVERSE = 2'd3
    } t_opcode;

    typedef enum logic [STAT_W-1:0] {
        ST_OK       = 3'd0,
        ST_RANGE    = 3'd1,
        ST_FULL     = 3'd2,
        ST_NOTFOUND = 3'd3,
        ST_EMPTY    = 3'd4
    } t_status;

    // what every cell does in a cycle
    typedef enum logic [1:0] {
        CELL_HOLD   = 2'd0,
        CELL_INSERT = 2'd1,
        CELL_DELETE = 2'd2,
        CELL_ROTATE = 2'd3
    } t_cell_op;

    // command broadcast to the row of cells
    typedef struct packed {
        t_cell_op                 op;
        logic signed [DATA_W-1:0] value;
    } t_cell_ctl;

    typedef enum logic [1:0] {
        S_IDLE   = 2'd0,
        S_SEARCH = 2'd1,
        S_TRAV   = 2'd2
    } t_state;

endpackage

FILE: sv/oaids_cell.sv
module oaids_cell #(
    parameter int IDX   = 0,
    parameter int CNT_W = 5
) (
    input  logic                                i_clk,
    input  oaids_pkg::t_cell_ctl                i_ctl,
    input  logic [CNT_W-1:0]                    i_pos,
    input  logic [CNT_W-1:0]                    i_count,
    input  logic signed [oaids_pkg::DATA_W-1:0] i_prev_data,
    input  logic signed [oaids_pkg::DATA_W-1:0] i_next_data,
    input  logic signed [oaids_pkg::DATA_W-1:0] i_head_data,
    output logic signed [oaids_pkg::DATA_W-1:0] o_data,
    output logic                                o_match
);

    localparam logic [CNT_W:0] IDX_V  = (CNT_W+1)'(IDX);
    localparam logic [CNT_W:0] IDX_P1 = (CNT_W+1)'(IDX + 1);

    logic signed [oaids_pkg::DATA_W-1:0] r_data;
    logic signed [oaids_pkg::DATA_W-1:0] n_data;
    logic                                r_match;
    logic [CNT_W:0]                      w_pos;
    logic [CNT_W:0]                      w_count;

    assign w_pos   = {1'b0, i_pos};
    assign w_count = {1'b0, i_count};

    // element taken from the command value, a neighbor or the head cell, or kept
    always_comb begin
        n_data = r_data;
        unique case (i_ctl.op)
            oaids_pkg::CELL_INSERT: begin
                if (IDX_V == w_pos) begin
                    n_data = i_ctl.value;
                end else if (IDX_V > w_pos && IDX_V <= w_count) begin
                    n_data = i_prev_data;
                end
            end
            oaids_pkg::CELL_DELETE: begin
                if (IDX_V >= w_pos && IDX_P1 < w_count) begin
                    n_data = i_next_data;
                end
            end
            oaids_pkg::CELL_ROTATE: begin
                if (IDX_P1 < w_count) begin
                    n_data = i_next_data;
                end else if (IDX_P1 == w_count) begin
                    n_data = i_head_data;
                end
            end
            default: n_data = r_data;
        endcase
    end

    // element storage and registered compare
    always_ff @(posedge i_clk) begin
        r_data  <= n_data;
        r_match <= (r_data == i_ctl.value) && (IDX_V < w_count);
    end

    assign o_data  = r_data;
    assign o_match = r_match;

endmodule

FILE: sv/ordered_array_insert_delete_search_core.sv
// channel  | valid        | stall        | payload
// ---------+--------------+--------------+------------------------------------------
// input    | i_in_valid   | o_in_stall   | i_opcode, i_value, i_position
// output   | o_out_valid  | i_out_stall  | o_status, o_found_position, o_element_out,
//          |              |              | o_count_after, o_last_item
//
// insert, delete and traverse of an empty store are answered from the idle state; search also passes S_SEARCH
// search: every cell compares and registers a match, then the first match is picked
// traverse: the transaction is taken in the idle state, then S_TRAV gives one result per element
// as the row rotates left a place per result, leaving the store back in order
// reset clears the element count and control only; cell contents are not cleared
// while a result is stalled at the output no new transaction is taken
module ordered_array_insert_delete_search_core #(
    parameter int CAPACITY = oaids_pkg::CAPACITY_DEF
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_in_valid,
    output logic                                 o_in_stall,
    input  logic [oaids_pkg::OP_W-1:0]           i_opcode,
    input  logic signed [oaids_pkg::DATA_W-1:0]  i_value,
    input  logic [oaids_pkg::POS_W-1:0]          i_position,
    output logic                                 o_out_valid,
    input  logic                                 i_out_stall,
    output logic [oaids_pkg::STAT_W-1:0]         o_status,
    output logic [oaids_pkg::FIELD_W-1:0]        o_found_position,
    output logic signed [oaids_pkg::DATA_W-1:0]  o_element_out,
    output logic [oaids_pkg::FIELD_W-1:0]        o_count_after,
    output logic                                 o_last_item
);

    localparam int CNT_W = $clog2(CAPACITY + 1);
    localparam int CMP_W = (CNT_W > oaids_pkg::POS_W) ? CNT_W : oaids_pkg::POS_W;
    localparam logic [CNT_W-1:0] CAP_V = CNT_W'(CAPACITY);

    oaids_pkg::t_state    r_state;
    oaids_pkg::t_state    n_state;
    oaids_pkg::t_cell_ctl w_ctl;
    oaids_pkg::t_opcode   w_op;

    logic [CNT_W-1:0] r_count;
    logic [CNT_W-1:0] n_count;
    logic [CNT_W-1:0] r_idx;
    logic [CNT_W-1:0] w_cell_pos;
    logic [CNT_W-1:0] w_found;
    logic             w_any_match;

    logic             r_out_valid;
    logic [oaids_pkg::STAT_W-1:0]        r_status;
    logic [oaids_pkg::FIELD_W-1:0]       r_found;
    logic signed [oaids_pkg::DATA_W-1:0] r_elem;
    logic [oaids_pkg::FIELD_W-1:0]       r_count_out;
    logic             r_last;

    logic             w_out_free;
    logic             w_in_fire;
    logic             w_load;
    logic             w_trav_last;
    logic [oaids_pkg::STAT_W-1:0]        w_status;
    logic [CNT_W-1:0]                    w_found_out;
    logic signed [oaids_pkg::DATA_W-1:0] w_elem;
    logic             w_last;

    logic [CMP_W-1:0] w_pos_x;
    logic [CMP_W-1:0] w_cnt_x;
    logic             w_ins_range;
    logic             w_full;
    logic             w_empty;
    logic             w_del_range;

    logic signed [oaids_pkg::DATA_W-1:0] w_data [CAPACITY];
    logic signed [oaids_pkg::DATA_W-1:0] w_prev [CAPACITY];
    logic signed [oaids_pkg::DATA_W-1:0] w_next [CAPACITY];
    logic [CAPACITY-1:0]                 w_match;

    // handshake
    assign w_out_free = !r_out_valid || !i_out_stall;
    assign o_in_stall = !((r_state == oaids_pkg::S_IDLE) && w_out_free);
    assign w_in_fire  = i_in_valid && !o_in_stall;
    assign w_op       = oaids_pkg::t_opcode'(i_opcode);

    // index checks
    assign w_pos_x     = CMP_W'(i_position);
    assign w_cnt_x     = CMP_W'(r_count);
    assign w_ins_range = w_pos_x > w_cnt_x;
    assign w_full      = r_count == CAP_V;
    assign w_empty     = r_count == '0;
    assign w_del_range = w_pos_x >= w_cnt_x;
    assign w_cell_pos  = CNT_W'(i_position);
    assign w_trav_last = (r_idx + CNT_W'(1)) == r_count;

    // first match wins
    always_comb begin
        w_found     = '0;
        w_any_match = 1'b0;
        for (int i = CAPACITY - 1; i >= 0; i--) begin
            if (w_match[i]) begin
                w_found     = CNT_W'(i + 1);
                w_any_match = 1'b1;
            end
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            oaids_pkg::S_IDLE: begin
                if (w_in_fire && w_op == oaids_pkg::OP_SEARCH) begin
                    n_state = oaids_pkg::S_SEARCH;
                end else if (w_in_fire && w_op == oaids_pkg::OP_TRAVERSE && !w_empty) begin
                    n_state = oaids_pkg::S_TRAV;
                end
            end
            oaids_pkg::S_SEARCH: begin
                if (w_out_free) begin
                    n_state = oaids_pkg::S_IDLE;
                end
            end
            oaids_pkg::S_TRAV: begin
                if (w_out_free && w_trav_last) begin
                    n_state = oaids_pkg::S_IDLE;
                end
            end
            default: n_state = oaids_pkg::S_IDLE;
        endcase
    end

    // outputs of the sequencer: cell command, result and count
    always_comb begin
        w_ctl.op    = oaids_pkg::CELL_HOLD;
        w_ctl.value = i_value;
        w_load      = 1'b0;
        w_status    = oaids_pkg::ST_OK;
        w_found_out = '0;
        w_elem      = '0;
        w_last      = 1'b1;
        n_count     = r_count;
        unique case (r_state)
            oaids_pkg::S_IDLE: begin
                if (w_in_fire) begin
                    unique case (w_op)
                        oaids_pkg::OP_INSERT: begin
                            w_load = 1'b1;
                            if (w_ins_range) begin
                                w_status = oaids_pkg::ST_RANGE;
                            end else if (w_full) begin
                                w_status = oaids_pkg::ST_FULL;
                            end else begin
                                w_ctl.op = oaids_pkg::CELL_INSERT;
                                n_count  = r_count + CNT_W'(1);
                            end
                        end
                        oaids_pkg::OP_DELETE: begin
                            w_load = 1'b1;
                            if (w_empty) begin
                                w_status = oaids_pkg::ST_EMPTY;
                            end else if (w_del_range) begin
                                w_status = oaids_pkg::ST_RANGE;
                            end else begin
                                w_ctl.op = oaids_pkg::CELL_DELETE;
                                n_count  = r_count - CNT_W'(1);
                            end
                        end
                        oaids_pkg::OP_SEARCH: begin
                            w_load = 1'b0;
                        end
                        oaids_pkg::OP_TRAVERSE: begin
                            if (w_empty) begin
                                w_load   = 1'b1;
                                w_status = oaids_pkg::ST_EMPTY;
                            end
                        end
                        default: w_load = 1'b0;
                    endcase
                end
            end
            oaids_pkg::S_SEARCH: begin
                if (w_out_free) begin
                    w_load      = 1'b1;
                    w_status    = w_any_match ? oaids_pkg::ST_OK : oaids_pkg::ST_NOTFOUND;
                    w_found_out = w_found;
                end
            end
            oaids_pkg::S_TRAV: begin
                if (w_out_free) begin
                    w_load      = 1'b1;
                    w_ctl.op    = oaids_pkg::CELL_ROTATE;
                    w_found_out = r_idx;
                    w_elem      = w_data[0];
                    w_last      = w_trav_last;
                end
            end
            default: w_load = 1'b0;
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= oaids_pkg::S_IDLE;
            r_count     <= '0;
            r_idx       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            if (r_state != oaids_pkg::S_TRAV) begin
                r_idx <= '0;
            end else if (w_out_free) begin
                r_idx <= r_idx + CNT_W'(1);
            end
            if (w_load) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_status    <= w_status;
            r_found     <= oaids_pkg::FIELD_W'(w_found_out);
            r_elem      <= w_elem;
            r_count_out <= oaids_pkg::FIELD_W'(n_count);
            r_last      <= w_last;
        end
    end

    // row of element cells
    for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
        if (g == 0) begin : g_first
            assign w_prev[g] = '0;
        end else begin : g_mid_p
            assign w_prev[g] = w_data[g-1];
        end
        if (g == CAPACITY - 1) begin : g_last
            assign w_next[g] = '0;
        end else begin : g_mid_n
            assign w_next[g] = w_data[g+1];
        end

        oaids_cell #(
            .IDX   (g),
            .CNT_W (CNT_W)
        ) u_cell (
            .i_clk       (i_clk),
            .i_ctl       (w_ctl),
            .i_pos       (w_cell_pos),
            .i_count     (r_count),
            .i_prev_data (w_prev[g]),
            .i_next_data (w_next[g]),
            .i_head_data (w_data[0]),
            .o_data      (w_data[g]),
            .o_match     (w_match[g])
        );
    end

    assign o_out_valid      = r_out_valid;
    assign o_status         = r_status;
    assign o_found_position = r_found;
    assign o_element_out    = r_elem;
    assign o_count_after    = r_count_out;
    assign o_last_item      = r_last;

endmodule

FILE: sim/ordered_array_insert_delete_search_core_tb.sv
module ordered_array_insert_delete_search_core_tb;

    localparam int CAP          = oaids_pkg::CAPACITY_DEF;
    localparam int OP_W         = oaids_pkg::OP_W;
    localparam int DATA_W       = oaids_pkg::DATA_W;
    localparam int POS_W        = oaids_pkg::POS_W;
    localparam int STAT_W       = oaids_pkg::STAT_W;
    localparam int FIELD_W      = oaids_pkg::FIELD_W;
    localparam int LIMIT_CYCLES = 200000;
    localparam int HOLD_CYCLES  = 60;
    localparam int IDLE_PCT     = 27;
    localparam int DRAIN_CYCLES = 20;

    // one result transaction as the block should emit it
    typedef struct {
        oaids_pkg::t_status       status;
        logic [FIELD_W-1:0]       found_pos;
        logic signed [DATA_W-1:0] element;
        logic [FIELD_W-1:0]       count;
        logic                     last;
    } t_array_result;

    logic                       i_clk = 1'b0;
    logic                       i_rst_n = 1'b0;
    logic                       i_in_valid = 1'b0;
    logic                       o_in_stall;
    logic [OP_W-1:0]            i_opcode = oaids_pkg::OP_INSERT;
    logic signed [DATA_W-1:0]   i_value = '0;
    logic [POS_W-1:0]           i_position = '0;
    logic                       o_out_valid;
    logic                       i_out_stall = 1'b0;
    logic [STAT_W-1:0]          o_status;
    logic [FIELD_W-1:0]         o_found_position;
    logic signed [DATA_W-1:0]   o_element_out;
    logic [FIELD_W-1:0]         o_count_after;
    logic                       o_last_item;

    // shadow copy of the element array
    logic signed [DATA_W-1:0]   shadow_cells [CAP];
    int                         shadow_count = 0;
    t_array_result              pending_results [$];

    int                         error_count = 0;
    int                         cycle_count = 0;
    bit                         calm = 1'b0;
    int                         hold_go = 0;
    int                         hold_seen = 0;
    int                         hold_left = 0;

    ordered_array_insert_delete_search_core #(
        .CAPACITY(CAP)
    ) dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_in_valid       (i_in_valid),
        .o_in_stall       (o_in_stall),
        .i_opcode         (i_opcode),
        .i_value          (i_value),
        .i_position       (i_position),
        .o_out_valid      (o_out_valid),
        .i_out_stall      (i_out_stall),
        .o_status         (o_status),
        .o_found_position (o_found_position),
        .o_element_out    (o_element_out),
        .o_count_after    (o_count_after),
        .o_last_item      (o_last_item)
    );

    // clock
    initial begin
        forever #2 i_clk = ~i_clk;
    end

    // run limit
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > LIMIT_CYCLES) begin
            $display("ordered_array_insert_delete_search_core: mismatch");
            $finish;
        end
    end

    // receiver: random stalls, long hold-off on request, none while calm
    always @(posedge i_clk) begin
        if (hold_left > 0) begin
            i_out_stall <= 1'b1;
            hold_left <= hold_left - 1;
        end else if (hold_seen != hold_go) begin
            hold_seen <= hold_go;
            hold_left <= HOLD_CYCLES - 1;
            i_out_stall <= 1'b1;
        end else begin
            i_out_stall <= !calm && ($urandom_range(99) < IDLE_PCT);
        end
    end

    function automatic void push_result(oaids_pkg::t_status st, int fpos,
                                        logic signed [DATA_W-1:0] elem, logic last);
        t_array_result r;
        r.status    = st;
        r.found_pos = FIELD_W'(fpos);
        r.element   = elem;
        r.count     = FIELD_W'(shadow_count);
        r.last      = last;
        pending_results.push_back(r);
    endfunction

    // update the shadow array and queue the results of one accepted transaction
    function automatic void apply_array_op(oaids_pkg::t_opcode op,
                                           logic signed [DATA_W-1:0] val,
                                           logic [POS_W-1:0] pos);
        int i;
        int hit;
        case (op)
            oaids_pkg::OP_INSERT: begin
                if (int'(pos) > shadow_count) begin
                    push_result(oaids_pkg::ST_RANGE, 0, '0, 1'b1);
                end else if (shadow_count >= CAP) begin
                    push_result(oaids_pkg::ST_FULL, 0, '0, 1'b1);
                end else begin
                    for (i = shadow_count; i > int'(pos); i--)
                        shadow_cells[i] = shadow_cells[i-1];
                    shadow_cells[pos] = val;
                    shadow_count++;
                    push_result(oaids_pkg::ST_OK, 0, '0, 1'b1);
                end
            end
            oaids_pkg::OP_DELETE: begin
                if (shadow_count == 0) begin
                    push_result(oaids_pkg::ST_EMPTY, 0, '0, 1'b1);
                end else if (int'(pos) >= shadow_count) begin
                    push_result(oaids_pkg::ST_RANGE, 0, '0, 1'b1);
                end else begin
                    for (i = pos; i + 1 < shadow_count; i++)
                        shadow_cells[i] = shadow_cells[i+1];
                    shadow_count--;
                    push_result(oaids_pkg::ST_OK, 0, '0, 1'b1);
                end
            end
            oaids_pkg::OP_SEARCH: begin
                hit = 0;
                for (i = 0; i < shadow_count && hit == 0; i++)
                    if (shadow_cells[i] == val)
                        hit = i + 1;
                push_result(hit != 0 ? oaids_pkg::ST_OK : oaids_pkg::ST_NOTFOUND,
                            hit, '0, 1'b1);
            end
            default: begin
                if (shadow_count == 0) begin
                    push_result(oaids_pkg::ST_EMPTY, 0, '0, 1'b1);
                end else begin
                    for (i = 0; i < shadow_count; i++)
                        push_result(oaids_pkg::ST_OK, i, shadow_cells[i],
                                    i + 1 == shadow_count);
                end
            end
        endcase
    endfunction

    function automatic void check_field(string name, logic [DATA_W-1:0] exp_v,
                                        logic [DATA_W-1:0] act_v);
        if (act_v !== exp_v) begin
            $display("%0t %s: expected %0h actual %0h", $time, name, exp_v, act_v);
            error_count++;
        end
    endfunction

    // result checker
    always @(posedge i_clk) begin
        t_array_result want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (pending_results.size() == 0) begin
                $display("%0t unexpected result: expected none actual status %0h elem %0h",
                         $time, o_status, o_element_out);
                error_count++;
            end else begin
                want = pending_results.pop_front();
                check_field("status", want.status, o_status);
                check_field("found_position", want.found_pos, o_found_position);
                check_field("element_out", want.element, o_element_out);
                check_field("count_after", want.count, o_count_after);
                check_field("last_item", want.last, o_last_item);
            end
        end
    end

    // offer one transaction and hold it until accepted
    task automatic send_op(oaids_pkg::t_opcode op, logic signed [DATA_W-1:0] val,
                           logic [POS_W-1:0] pos);
        if (!calm) begin
            while ($urandom_range(99) < IDLE_PCT) begin
                i_in_valid <= 1'b0;
                @(posedge i_clk);
            end
        end
        i_in_valid <= 1'b1;
        i_opcode   <= op;
        i_value    <= val;
        i_position <= pos;
        @(posedge i_clk);
        while (o_in_stall)
            @(posedge i_clk);
        apply_array_op(op, val, pos);
    endtask

    task automatic wait_results_drained();
        i_in_valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge i_clk);
    endtask

    // mix of extremes, small colliding values, stored values and noise
    function automatic logic signed [DATA_W-1:0] pick_value();
        case ($urandom_range(3))
            0: return $urandom();
            1: return $urandom_range(7) - 3;
            2: begin
                case ($urandom_range(2))
                    0: return 32'sh8000_0000;
                    1: return 32'sh7fff_ffff;
                    default: return '0;
                endcase
            end
            default: begin
                if (shadow_count == 0)
                    return $urandom();
                return shadow_cells[$urandom_range(shadow_count - 1)];
            end
        endcase
    endfunction

    // operations on an empty array
    task automatic test_empty_store();
        send_op(oaids_pkg::OP_TRAVERSE, 32'sd5, 5'd0);
        send_op(oaids_pkg::OP_DELETE, '0, 5'd0);
        send_op(oaids_pkg::OP_SEARCH, '0, 5'd0);
        send_op(oaids_pkg::OP_INSERT, 32'sd9, 5'd1);
        send_op(oaids_pkg::OP_DELETE, -32'sd1, 5'd31);
    endtask

    // fill at front, end and middle, first with extreme values, then with random ones
    task automatic test_fill_to_capacity();
        logic signed [DATA_W-1:0] v;
        logic [POS_W-1:0]         p;
        for (int i = 0; i < CAP; i++) begin
            case (i)
                0: v = 32'sh8000_0000;
                1: v = 32'sh7fff_ffff;
                2, 4: v = -32'sd1;
                3: v = '0;
                default: v = $urandom();
            endcase
            case (i % 3)
                0: p = 5'd0;
                1: p = POS_W'(shadow_count);
                default: p = POS_W'(shadow_count / 2);
            endcase
            send_op(oaids_pkg::OP_INSERT, v, p);
        end
    endtask

    // full array: full vs out-of-range precedence, full traverse, duplicate search
    task automatic test_full_store();
        send_op(oaids_pkg::OP_INSERT, 32'sd7, 5'd16);
        send_op(oaids_pkg::OP_INSERT, 32'sd7, 5'd17);
        send_op(oaids_pkg::OP_TRAVERSE, '0, 5'd0);
        send_op(oaids_pkg::OP_SEARCH, -32'sd1, 5'd0);
        send_op(oaids_pkg::OP_SEARCH, 32'sh8000_0000, 5'd0);
        send_op(oaids_pkg::OP_DELETE, '0, 5'd16);
        send_op(oaids_pkg::OP_DELETE, '0, 5'd15);
        send_op(oaids_pkg::OP_DELETE, '0, 5'd0);
    endtask

    // mostly well-formed random operations, some out-of-range positions
    task automatic test_random_ops(int n, int insert_pct);
        oaids_pkg::t_opcode op;
        logic [POS_W-1:0]   pos;
        int                 r;
        repeat (n) begin
            r = $urandom_range(99);
            if (r < insert_pct)
                op = oaids_pkg::OP_INSERT;
            else if (r < 75)
                op = oaids_pkg::OP_DELETE;
            else if (r < 90)
                op = oaids_pkg::OP_SEARCH;
            else
                op = oaids_pkg::OP_TRAVERSE;
            if ($urandom_range(9) == 0)
                pos = POS_W'($urandom_range(31));
            else if (op == oaids_pkg::OP_INSERT)
                pos = POS_W'($urandom_range(shadow_count));
            else if (shadow_count == 0)
                pos = '0;
            else
                pos = POS_W'($urandom_range(shadow_count - 1));
            send_op(op, pick_value(), pos);
        end
    endtask

    // receiver holds off while the sender keeps offering back to back
    task automatic test_output_holdoff();
        calm = 1'b1;
        hold_go++;
        test_random_ops(15, 50);
        calm = 1'b0;
    endtask

    // sender pauses until the pipeline is empty, then resumes
    task automatic test_sender_pause();
        test_random_ops(10, 55);
        wait_results_drained();
        test_random_ops(15, 40);
    endtask

    // long stretch with no idling on either side
    task automatic test_no_idle_burst();
        calm = 1'b1;
        test_random_ops(20, 45);
        calm = 1'b0;
    endtask

    initial begin
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_empty_store();
        test_fill_to_capacity();
        test_full_store();
        test_random_ops(20, 65);
        test_output_holdoff();
        test_sender_pause();
        test_no_idle_burst();
        test_random_ops(15, 25);
        wait_results_drained();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (error_count == 0)
            $display("ordered_array_insert_delete_search_core: match");
        else
            $display("ordered_array_insert_delete_search_core: mismatch");
        $finish;
    end

endmodule

FILE: filelist.f
sv/oaids_pkg.sv
sv/oaids_cell.sv
sv/ordered_array_insert_delete_search_core.sv
sim/ordered_array_insert_delete_search_core_tb.sv
